// ===== hw/rtl/spq_pkg.sv =====
// spq_pkg: shared types and codes for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue_top; no dependencies.
package spq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int VALUE_W     = 32;
	localparam int PRIO_W      = 16;
	localparam int STATUS_W    = 2;
	localparam int OCC_W       = 5;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic        [PRIO_W-1:0]  prio;
	} entry_t;

	// broadcast from the queue control to every cell
	typedef struct packed {
		logic   ins;
		logic   rem;
		entry_t entry;
	} cell_ctrl_t;

endpackage

// ===== hw/rtl/sorted_priority_queue_top.sv =====
// sorted_priority_queue_top: bounded priority queue built from a chain of spq_cell slots.
// Depends on spq_pkg and spq_cell.
//
// Takes one insert or remove beat per clock cycle and returns one result beat for each,
// in the cycle after acceptance. Entries are kept sorted in a row of DEPTH cells, slot 0
// holding the smallest priority number; every cell compares its own priority with the
// incoming one in parallel, so an insert or remove takes the same time whatever the fill
// level. Equal priorities leave in arrival order. A result waits in an output register;
// the input stalls only while that register is full and the output is stalled.
// Insert on a full queue reports status full, remove on an empty queue status empty; both
// leave the queue unchanged. occupancy gives the count after the operation.
module sorted_priority_queue_top #(
	parameter int DEPTH = spq_pkg::QUEUE_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                opcode,
	input  logic signed [spq_pkg::VALUE_W-1:0]  in_value,
	input  logic        [spq_pkg::PRIO_W-1:0]   in_priority,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic        [spq_pkg::STATUS_W-1:0] status,
	output logic signed [spq_pkg::VALUE_W-1:0]  out_value,
	output logic        [spq_pkg::PRIO_W-1:0]   out_priority,
	output logic        [spq_pkg::OCC_W-1:0]    occupancy
);
	import spq_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;
	logic [STATUS_W-1:0] status_q;
	entry_t           head_q;
	logic [CNT_W-1:0] count_nxt;
	logic [CNT_W+OCC_W-1:0] count_ext;

	logic       accept;
	logic       is_full;
	logic       is_empty;
	cell_ctrl_t ctrl;

	entry_t     entries [DEPTH];
	logic [DEPTH-1:0] keeps;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign is_full  = (count_q == CNT_W'(DEPTH));
	assign is_empty = (count_q == '0);

	assign ctrl.ins         = accept && (opcode == OP_INSERT) && !is_full;
	assign ctrl.rem         = accept && (opcode == OP_REMOVE) && !is_empty;
	assign ctrl.entry.value = in_value;
	assign ctrl.entry.prio  = in_priority;

	always_comb begin
		count_nxt = count_q;
		if (ctrl.ins) begin
			count_nxt = count_q + 1'b1;
		end else if (ctrl.rem) begin
			count_nxt = count_q - 1'b1;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic   occ;
		logic   left_keep;
		entry_t left_entry;
		entry_t right_entry;

		assign occ = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_first
			assign left_keep  = 1'b1;
			assign left_entry = '0;
		end else begin : g_mid
			assign left_keep  = keeps[i-1];
			assign left_entry = entries[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_entry = '0;
		end else begin : g_inner
			assign right_entry = entries[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occ         (occ),
			.left_keep   (left_keep),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.keep        (keeps[i]),
			.entry       (entries[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, loaded with each accepted beat
	always_ff @(posedge clk) begin
		if (accept) begin
			head_q <= ctrl.rem ? entries[0] : '0;
			if (opcode == OP_INSERT) begin
				status_q <= is_full ? ST_FULL : ST_OK;
			end else begin
				status_q <= is_empty ? ST_EMPTY : ST_OK;
			end
		end
	end

	logic [CNT_W-1:0] occ_q;
	always_ff @(posedge clk) begin
		if (accept) begin
			occ_q <= count_nxt;
		end
	end

	assign count_ext    = {{OCC_W{1'b0}}, occ_q};
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_value    = head_q.value;
	assign out_priority = head_q.prio;
	assign occupancy    = count_ext[OCC_W-1:0];

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (opcode == OP_INSERT) && is_full |=> $stable(count_q) && status == ST_FULL)
		else $error("insert on full queue changed the count");

	a_empty_report: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> occ_q == '0)
		else $error("empty status with nonzero occupancy");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q && occ_q == count_q)
		else $error("result beat missing or occupancy out of step");

	a_keep_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(keeps ^ {keeps[DEPTH-2:0], 1'b1}))
		else $error("cells kept in place do not form a prefix");

endmodule

// ===== hw/rtl/spq_cell.sv =====
// spq_cell: one slot of the sorted chain, holds one entry.
// Depends on spq_pkg; instantiated in a row by sorted_priority_queue_top.
module spq_cell (
	input  logic               clk,
	input  spq_pkg::cell_ctrl_t ctrl,
	input  logic               occ,
	input  logic               left_keep,
	input  spq_pkg::entry_t    left_entry,
	input  spq_pkg::entry_t    right_entry,
	output logic               keep,
	output spq_pkg::entry_t    entry
);
	import spq_pkg::*;

	entry_t entry_q;

	// an occupied slot whose priority is lower or equal stays in place on insert
	assign keep  = occ && (entry_q.prio <= ctrl.entry.prio);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (!keep) begin
				// first slot that moves takes the new entry, the rest shift right
				entry_q <= left_keep ? ctrl.entry : left_entry;
			end
		end else if (ctrl.rem) begin
			entry_q <= right_entry;
		end
	end

endmodule
